/* rtl/lweg_pkg.sv */
// Package for the LED weather effect generator.
// Holds mode and register codes, the shared multiplier types and the breath ROM function.
// No dependencies.
package lweg_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int CHAN_W     = 8;
    localparam int PHASE_W    = 16;
    localparam int ACC_W      = 24;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_BRIGHT = 3'd1;
    localparam logic [2:0] REG_RATE   = 3'd2;
    localparam logic [2:0] REG_STEP   = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    localparam logic [2:0] MODE_THUNDER = 3'd0;
    localparam logic [2:0] MODE_SUNNY   = 3'd1;
    localparam logic [2:0] MODE_RAINY   = 3'd2;
    localparam logic [2:0] MODE_SNOWY   = 3'd3;
    localparam logic [2:0] MODE_FOGGY   = 3'd4;
    localparam logic [2:0] MODE_CLOUDY  = 3'd5;
    localparam logic [2:0] MODE_NIGHT   = 3'd6;

    localparam logic [6:0]  BRIGHT_MAX   = 7'd100;
    localparam logic [9:0]  FLASH_CHANCE = 10'd10;
    localparam logic [11:0] NIGHT_MUL    = 12'd3507;
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_SHIFT  = 19;

    localparam logic [63:0] POLY_A = 64'd102944;
    localparam logic [63:0] POLY_B = 64'd42048;
    localparam logic [63:0] POLY_C = 64'd4640;
    localparam logic [63:0] ONE_Q16 = 64'd65536;

    typedef enum logic [2:0] {
        MUL_TPHASE,
        MUL_NSTEP,
        MUL_SQUARE,
        MUL_CUBE,
        MUL_AMP,
        MUL_BRIGHT,
        MUL_RECIP
    } mul_op_t;

    typedef struct packed {
        logic [23:0] time_lo;
        logic [15:0] rate;
        logic [15:0] step;
        logic [7:0]  breath;
        logic [15:0] square;
        logic [7:0]  level;
        logic [7:0]  amp;
        logic [7:0]  raw;
        logic [6:0]  bright;
        logic [14:0] num;
    } mul_src_t;

    // Breath value (0..255) of one sine ROM entry; the ROM holds 2^bits entries per turn.
    function automatic logic [7:0] breath_entry(int unsigned idx, int unsigned bits);
        logic [63:0] quad;
        logic [63:0] pos;
        logic [63:0] x;
        logic [63:0] xx;
        logic [63:0] t;
        logic [63:0] level;
        quad = 64'(idx) >> (bits - 2);
        pos  = 64'(idx) & ((64'd1 << (bits - 2)) - 64'd1);
        x    = pos << (18 - bits);
        if (quad[0])
        begin
            x = ONE_Q16 - x;
        end
        xx = (x * x) >> 16;
        t  = (POLY_C * xx) >> 16;
        t  = POLY_B - t;
        t  = (t * xx) >> 16;
        t  = POLY_A - t;
        t  = (t * x) >> 16;
        if (t > ONE_Q16)
        begin
            t = ONE_Q16;
        end
        level = quad[1] ? (ONE_Q16 - t) : (ONE_Q16 + t);
        return 8'(((level * 64'd255) + ONE_Q16) >> 17);
    endfunction

endpackage

/* rtl/lweg_if.sv */
// Valid/ready channel interfaces for frame requests and pixel results.
// No dependencies.
interface lweg_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;
    logic [9:0]  chance;

    modport source (output valid, output time_ms, output chance, input ready);
    modport sink (input valid, input time_ms, input chance, output ready);
endinterface

interface lweg_pixel_if;
    logic       valid;
    logic       ready;
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic       last_pixel;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, output white, output last_pixel, input ready);
    modport sink (input valid, input pixel_index, input red, input green,
                  input blue, input white, input last_pixel, output ready);
endinterface

/* rtl/lweg_breath_rom.sv */
// Breath ROM: sine mapped to 0..255 per phase index, with a registered read.
// Depends on lweg_pkg.
module lweg_breath_rom #(
    parameter int TABLE_BITS = 8
) (
    input  logic                  clk,
    input  logic [TABLE_BITS-1:0] addr,
    output logic [7:0]            breath
);
    localparam int DEPTH = 1 << TABLE_BITS;

    logic [7:0] rom_tbl [DEPTH];
    logic [7:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_rom
        assign rom_tbl[k] = lweg_pkg::breath_entry(k, TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_tbl[addr];
    end

    assign breath = data_reg;
endmodule

/* rtl/lweg_mul_unit.sv */
// Shared multiplier with operand selection for every product the sequencer needs.
// Depends on lweg_pkg.
module lweg_mul_unit (
    input  lweg_pkg::mul_op_t                op,
    input  lweg_pkg::mul_src_t               src,
    output logic [lweg_pkg::PROD_W-1:0]      prod
);
    logic [lweg_pkg::MUL_A_W-1:0] opa;
    logic [lweg_pkg::MUL_B_W-1:0] opb;

    always_comb
    begin
        unique case (op)
            lweg_pkg::MUL_TPHASE:
            begin
                opa = src.time_lo;
                opb = src.rate;
            end
            lweg_pkg::MUL_NSTEP:
            begin
                opa = 24'(src.step);
                opb = 16'(lweg_pkg::NIGHT_MUL);
            end
            lweg_pkg::MUL_SQUARE:
            begin
                opa = 24'(src.breath);
                opb = 16'(src.breath);
            end
            lweg_pkg::MUL_CUBE:
            begin
                opa = 24'(src.square);
                opb = 16'(src.breath);
            end
            lweg_pkg::MUL_AMP:
            begin
                opa = 24'(src.level);
                opb = 16'(src.amp);
            end
            lweg_pkg::MUL_BRIGHT:
            begin
                opa = 24'(src.raw);
                opb = 16'(src.bright);
            end
            lweg_pkg::MUL_RECIP:
            begin
                opa = 24'(src.num);
                opb = 16'(lweg_pkg::RECIP_100);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod = lweg_pkg::PROD_W'(opa) * lweg_pkg::PROD_W'(opb);
endmodule

/* rtl/lweg_flash.sv */
// Five-step lightning machine for thunderstorm mode, advanced once per frame request.
// Depends on lweg_pkg.
module lweg_flash (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  logic       mode_clear,
    input  logic [2:0] mode,
    input  logic [9:0] chance,
    output logic [7:0] flash_level
);
    typedef enum logic [2:0] {
        FL_IDLE,
        FL_BRIGHT,
        FL_DARK,
        FL_AFTER,
        FL_TAIL
    } fl_state_t;

    localparam logic [7:0] LEVEL_BRIGHT = 8'd120;
    localparam logic [7:0] LEVEL_AFTER  = 8'd30;

    fl_state_t  phase_reg, phase_next;
    logic [2:0] ticks_reg, ticks_next;
    logic [7:0] level_reg, level_next;
    logic [2:0] ticks_inc;

    assign ticks_inc = ticks_reg + 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        level_next = level_reg;
        if (mode_clear)
        begin
            phase_next = FL_IDLE;
            ticks_next = '0;
        end
        else if (tick)
        begin
            level_next = '0;
            if (mode == lweg_pkg::MODE_THUNDER)
            begin
                if (phase_reg == FL_IDLE)
                begin
                    if (chance < lweg_pkg::FLASH_CHANCE)
                    begin
                        phase_next = FL_BRIGHT;
                        ticks_next = '0;
                    end
                end
                else
                begin
                    ticks_next = ticks_inc;
                    unique case (phase_reg)
                        FL_BRIGHT:
                        begin
                            level_next = LEVEL_BRIGHT;
                            if (ticks_inc > 3'd2)
                            begin
                                phase_next = FL_DARK;
                                ticks_next = '0;
                            end
                        end
                        FL_DARK:
                        begin
                            if (ticks_inc > 3'd3)
                            begin
                                phase_next = FL_AFTER;
                                ticks_next = '0;
                            end
                        end
                        FL_AFTER:
                        begin
                            level_next = LEVEL_AFTER;
                            if (ticks_inc > 3'd2)
                            begin
                                phase_next = FL_TAIL;
                                ticks_next = '0;
                            end
                        end
                        default:
                        begin
                            if (ticks_inc > 3'd4)
                            begin
                                phase_next = FL_IDLE;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= FL_IDLE;
            ticks_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            level_reg <= level_next;
        end
    end

    assign flash_level = level_reg;

    a_clear_idles: assert property (@(posedge clk) disable iff (!rst_n)
        mode_clear |=> (phase_reg == FL_IDLE && ticks_reg == 3'd0))
        else $error("flash machine not idle after mode write");

    a_bright_level: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && !mode_clear && mode == lweg_pkg::MODE_THUNDER && phase_reg == FL_BRIGHT)
        |=> (flash_level == LEVEL_BRIGHT))
        else $error("bright step did not give the bright flash level");
endmodule

/* rtl/led_weather_effect_generator_unit.sv */
// Top level of the LED weather effect generator: APB registers and the pixel sequencer.
// Depends on lweg_pkg, lweg_if, lweg_breath_rom, lweg_mul_unit and lweg_flash.
//
//   Channel   Direction  Handshake       Payload
//   frame     in         valid/ready     time_ms, chance
//   pixel     out        valid/ready     pixel_index, red, green, blue, white, last_pixel
//   apb       in         psel/penable    paddr, pwdata, prdata (pready always high)
//
// A frame request first forms the two phase products; each pixel then takes a ROM read, a
// level step (square and cube for night non-moon pixels), the channel steps and an emit.
// All products go through one shared multiplier; the channel loop uses it 12 times a pixel.
// The pixel output register lets the next pixel be computed while one waits; the
// sequencer stalls only when a new pixel is ready and the previous one is still held.
// Reset is asynchronous, active low, and leaves no clearing pass.
module led_weather_effect_generator_unit #(
    parameter int LED_LIMIT       = 64,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lweg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lweg_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lweg_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    lweg_frame_if.sink                      frame,
    lweg_pixel_if.source                    pixel
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_TPH,
        S_STEP,
        S_ROM,
        S_LVL,
        S_CUBE1,
        S_CUBE2,
        S_AMP,
        S_BRT,
        S_DIV,
        S_EMIT
    } seq_state_t;

    seq_state_t state_reg, state_next;

    logic [2:0]  mode_reg;
    logic [6:0]  bright_reg;
    logic [15:0] rate_reg;
    logic [15:0] step_reg;
    logic [6:0]  count_reg;

    logic [23:0] time_lo_reg, time_lo_next;
    logic [15:0] tphase_reg, tphase_next;
    logic [lweg_pkg::ACC_W-1:0] inc_reg, inc_next;
    logic [lweg_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [5:0]  idx_reg, idx_next;
    logic [1:0]  ch_reg, ch_next;
    logic [15:0] sq_reg, sq_next;
    logic [7:0]  lvl_reg, lvl_next;
    logic [7:0]  raw_reg, raw_next;
    logic [14:0] num_reg, num_next;
    logic [31:0] chan_reg, chan_next;
    logic        ovalid_reg, ovalid_next;
    logic [5:0]  oidx_reg, oidx_next;
    logic [31:0] orgbw_reg, orgbw_next;
    logic        olast_reg, olast_next;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [6:0]  count_eff;
    logic        is_last;
    logic        is_moon;
    logic [15:0] phase_w;
    logic [7:0]  breath;
    logic [7:0]  flash_level;
    logic [31:0] bases;
    logic [31:0] amps;
    logic [7:0]  cur_base;
    logic [7:0]  cur_amp;
    logic [7:0]  scaled;
    logic        out_free;
    lweg_pkg::mul_op_t  mul_op;
    lweg_pkg::mul_src_t mul_src;
    logic [lweg_pkg::PROD_W-1:0] prod;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lweg_pkg::MODE_SUNNY;
            bright_reg <= lweg_pkg::BRIGHT_MAX;
            rate_reg   <= 16'd256;
            step_reg   <= '0;
            count_reg  <= 7'd64;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                lweg_pkg::REG_MODE:   mode_reg <= pwdata[2:0];
                lweg_pkg::REG_BRIGHT: bright_reg <= (pwdata[6:0] > lweg_pkg::BRIGHT_MAX)
                                                    ? lweg_pkg::BRIGHT_MAX : pwdata[6:0];
                lweg_pkg::REG_RATE:   rate_reg <= pwdata[15:0];
                lweg_pkg::REG_STEP:   step_reg <= pwdata[15:0];
                lweg_pkg::REG_COUNT:  count_reg <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            lweg_pkg::REG_MODE:   prdata = 32'(mode_reg);
            lweg_pkg::REG_BRIGHT: prdata = 32'(bright_reg);
            lweg_pkg::REG_RATE:   prdata = 32'(rate_reg);
            lweg_pkg::REG_STEP:   prdata = 32'(step_reg);
            lweg_pkg::REG_COUNT:  prdata = 32'(count_reg);
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        priority if (count_reg == 7'd0)
        begin
            count_eff = 7'd1;
        end
        else if (count_reg > 7'(LED_LIMIT))
        begin
            count_eff = 7'(LED_LIMIT);
        end
        else
        begin
            count_eff = count_reg;
        end
    end

    assign is_last = ({1'b0, idx_reg} + 7'd1) == count_eff;
    assign is_moon = (mode_reg == lweg_pkg::MODE_NIGHT) && (idx_reg == 6'd0);
    assign phase_w = tphase_reg + acc_reg[23:8];

    lweg_breath_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk    (clk),
        .addr   (phase_w[15 -: SINE_TABLE_BITS]),
        .breath (breath)
    );

    lweg_flash u_flash (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (frame.valid && frame.ready),
        .mode_clear  (cfg_wr && cfg_idx == lweg_pkg::REG_MODE),
        .mode        (mode_reg),
        .chance      (frame.chance),
        .flash_level (flash_level)
    );

    // Base and amplitude per channel, packed red, green, blue, white from the top byte.
    always_comb
    begin
        bases = '0;
        amps  = '0;
        unique case (mode_reg)
            lweg_pkg::MODE_THUNDER:
            begin
                bases = {8'd0, 8'd5, 8'd30, flash_level};
                amps  = {8'd0, 8'd15, 8'd80, 8'd0};
            end
            lweg_pkg::MODE_SUNNY:
            begin
                bases = {8'd10, 8'd2, 8'd0, 8'd0};
                amps  = {8'd200, 8'd70, 8'd0, 8'd0};
            end
            lweg_pkg::MODE_RAINY:
            begin
                bases = {8'd0, 8'd10, 8'd40, 8'd0};
                amps  = {8'd0, 8'd30, 8'd110, 8'd0};
            end
            lweg_pkg::MODE_SNOWY:
            begin
                bases = {8'd0, 8'd5, 8'd20, 8'd10};
                amps  = {8'd0, 8'd10, 8'd40, 8'd40};
            end
            lweg_pkg::MODE_FOGGY:
            begin
                bases = {8'd20, 8'd15, 8'd5, 8'd10};
                amps  = {8'd20, 8'd15, 8'd5, 8'd20};
            end
            lweg_pkg::MODE_CLOUDY:
            begin
                bases = {8'd5, 8'd10, 8'd20, 8'd5};
                amps  = {8'd5, 8'd10, 8'd20, 8'd10};
            end
            lweg_pkg::MODE_NIGHT:
            begin
                if (is_moon)
                begin
                    bases = {8'd60, 8'd40, 8'd10, 8'd10};
                end
                else
                begin
                    bases = {8'd2, 8'd0, 8'd10, 8'd0};
                    amps  = {8'd15, 8'd0, 8'd50, 8'd20};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cur_base = bases[31 - 8 * ch_reg -: 8];
    assign cur_amp  = amps[31 - 8 * ch_reg -: 8];

    always_comb
    begin
        mul_src.time_lo = time_lo_reg;
        mul_src.rate    = rate_reg;
        mul_src.step    = step_reg;
        mul_src.breath  = breath;
        mul_src.square  = sq_reg;
        mul_src.level   = lvl_reg;
        mul_src.amp     = cur_amp;
        mul_src.raw     = raw_reg;
        mul_src.bright  = bright_reg;
        mul_src.num     = num_reg;
        unique case (state_reg)
            S_TPH:   mul_op = lweg_pkg::MUL_TPHASE;
            S_STEP:  mul_op = lweg_pkg::MUL_NSTEP;
            S_CUBE1: mul_op = lweg_pkg::MUL_SQUARE;
            S_CUBE2: mul_op = lweg_pkg::MUL_CUBE;
            S_BRT:   mul_op = lweg_pkg::MUL_BRIGHT;
            S_DIV:   mul_op = lweg_pkg::MUL_RECIP;
            default: mul_op = lweg_pkg::MUL_AMP;
        endcase
    end

    lweg_mul_unit u_mul (
        .op   (mul_op),
        .src  (mul_src),
        .prod (prod)
    );

    assign scaled   = prod[lweg_pkg::RECIP_SHIFT +: 8];
    assign out_free = !ovalid_reg || pixel.ready;

    always_comb
    begin
        state_next   = state_reg;
        time_lo_next = time_lo_reg;
        tphase_next  = tphase_reg;
        inc_next     = inc_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        ch_next      = ch_reg;
        sq_next      = sq_reg;
        lvl_next     = lvl_reg;
        raw_next     = raw_reg;
        num_next     = num_reg;
        chan_next    = chan_reg;
        ovalid_next  = ovalid_reg && !pixel.ready;
        oidx_next    = oidx_reg;
        orgbw_next   = orgbw_reg;
        olast_next   = olast_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (frame.valid)
                begin
                    time_lo_next = frame.time_ms[23:0];
                    state_next   = S_TPH;
                end
            end
            S_TPH:
            begin
                tphase_next = prod[23:8];
                state_next  = S_STEP;
            end
            S_STEP:
            begin
                if (mode_reg == lweg_pkg::MODE_NIGHT)
                begin
                    inc_next = prod[23:0];
                end
                else if (mode_reg == lweg_pkg::MODE_FOGGY || mode_reg == lweg_pkg::MODE_CLOUDY)
                begin
                    inc_next = '0;
                end
                else
                begin
                    inc_next = {step_reg, 8'd0};
                end
                acc_next   = '0;
                idx_next   = '0;
                state_next = S_ROM;
            end
            S_ROM:
            begin
                ch_next = '0;
                if (mode_reg == lweg_pkg::MODE_NIGHT && !is_moon)
                begin
                    state_next = S_CUBE1;
                end
                else
                begin
                    state_next = S_LVL;
                end
            end
            S_LVL:
            begin
                lvl_next   = breath;
                state_next = S_AMP;
            end
            S_CUBE1:
            begin
                sq_next    = prod[15:0];
                state_next = S_CUBE2;
            end
            S_CUBE2:
            begin
                lvl_next   = prod[23:16];
                state_next = S_AMP;
            end
            S_AMP:
            begin
                raw_next   = cur_base + prod[15:8];
                state_next = S_BRT;
            end
            S_BRT:
            begin
                num_next   = prod[14:0];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                chan_next[31 - 8 * ch_reg -: 8] = scaled;
                ch_next = ch_reg + 2'd1;
                if (ch_reg == 2'd3)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_AMP;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oidx_next   = idx_reg;
                    orgbw_next  = chan_reg;
                    olast_next  = is_last;
                    idx_next    = idx_reg + 6'd1;
                    acc_next    = acc_reg + inc_reg;
                    state_next  = is_last ? S_IDLE : S_ROM;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            time_lo_reg <= '0;
            tphase_reg  <= '0;
            inc_reg     <= '0;
            acc_reg     <= '0;
            idx_reg     <= '0;
            ch_reg      <= '0;
            sq_reg      <= '0;
            lvl_reg     <= '0;
            raw_reg     <= '0;
            num_reg     <= '0;
            chan_reg    <= '0;
            ovalid_reg  <= 1'b0;
            oidx_reg    <= '0;
            orgbw_reg   <= '0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            time_lo_reg <= time_lo_next;
            tphase_reg  <= tphase_next;
            inc_reg     <= inc_next;
            acc_reg     <= acc_next;
            idx_reg     <= idx_next;
            ch_reg      <= ch_next;
            sq_reg      <= sq_next;
            lvl_reg     <= lvl_next;
            raw_reg     <= raw_next;
            num_reg     <= num_next;
            chan_reg    <= chan_next;
            ovalid_reg  <= ovalid_next;
            oidx_reg    <= oidx_next;
            orgbw_reg   <= orgbw_next;
            olast_reg   <= olast_next;
        end
    end

    assign frame.ready       = (state_reg == S_IDLE);
    assign pixel.valid       = ovalid_reg;
    assign pixel.pixel_index = oidx_reg;
    assign pixel.red         = orgbw_reg[31:24];
    assign pixel.green       = orgbw_reg[23:16];
    assign pixel.blue        = orgbw_reg[15:8];
    assign pixel.white       = orgbw_reg[7:0];
    assign pixel.last_pixel  = olast_reg;

    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.last_pixel) |-> (({1'b0, pixel.pixel_index} + 7'd1) == count_eff))
        else $error("last pixel flag does not match the LED count");

    a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready) |=> !frame.ready)
        else $error("sequencer ready again right after taking a frame");

    a_busy_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready && !pixel.last_pixel) |-> !frame.ready)
        else $error("sequencer idle while a frame is only partly delivered");

    a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
        bright_reg <= lweg_pkg::BRIGHT_MAX)
        else $error("brightness register above its limit");
endmodule
